// ===== rtl/tpa_pkg.sv =====
`default_nettype none

package tpa_pkg;

  // Input coordinate and result widths
  localparam int unsigned COORD_W = 16;
  localparam int unsigned PERIM_W = 27;
  localparam int unsigned AREA_W  = 40;

  // Side square root: 50-bit radicand (49 used), 25-bit root, one bit per stage
  localparam int unsigned SIDE_K  = 25;
  localparam int unsigned SIDE_RW = 2 * SIDE_K;

  // Area square root: 108-bit radicand, 54-bit root, one bit per stage
  localparam int unsigned AREA_K     = 54;
  localparam int unsigned AREA_RW    = 2 * AREA_K;
  localparam int unsigned AREA_SHIFT = 10;

  // Factor products and their 27-bit halves
  localparam int unsigned HALF_W = 27;
  localparam int unsigned PROD_W = 2 * HALF_W;

  // Side unit: diff, square, sum stages, then the root stages
  localparam int unsigned SIDE_LAT = 3 + SIDE_K;

  // Input register, side unit, four product stages, root entry, root stages
  localparam int unsigned TOTAL_LAT = 1 + SIDE_LAT + 4 + 1 + AREA_K;

endpackage

`default_nettype wire

// ===== rtl/triangle_perimeter_area.sv =====
// Channel   Direction  Handshake          Payload
// vertices  in         start / busy       ax_i ay_i bx_i by_coord_i cx_i cy_i
// result    out        done_o (strobe)    perimeter_q8_o area_q8_o
//
// One triangle is taken every cycle; busy stays low.
// Each result appears for one cycle.
// Latency is set by the two bit-per-stage square roots (25 and 54 stages).
// Reset clears only the valid bits; payload registers are not reset.
// Results leave in item order and the receiver cannot stall the pipeline.
`default_nettype none

module triangle_perimeter_area (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic signed [tpa_pkg::COORD_W-1:0]  ax_i,
  input  wire logic signed [tpa_pkg::COORD_W-1:0]  ay_i,
  input  wire logic signed [tpa_pkg::COORD_W-1:0]  bx_i,
  input  wire logic signed [tpa_pkg::COORD_W-1:0]  by_coord_i,
  input  wire logic signed [tpa_pkg::COORD_W-1:0]  cx_i,
  input  wire logic signed [tpa_pkg::COORD_W-1:0]  cy_i,
  output logic                                     done_o,
  output logic             [tpa_pkg::PERIM_W-1:0]  perimeter_q8_o,
  output logic             [tpa_pkg::AREA_W-1:0]   area_q8_o
);

  localparam int unsigned CW = tpa_pkg::COORD_W;
  localparam int unsigned PW = tpa_pkg::PERIM_W;
  localparam int unsigned SW = tpa_pkg::SIDE_K;
  localparam int unsigned HW = tpa_pkg::HALF_W;
  localparam int unsigned MW = tpa_pkg::PROD_W;
  localparam int unsigned SL = tpa_pkg::SIDE_LAT;

  logic signed [CW-1:0] ax_q, ay_q, bx_q, by_q, cx_q, cy_q;
  logic                 vin_q;
  logic                 vs_q [SL];
  logic [SW-1:0]        side_a, side_b, side_c;

  logic                 v1_q, v2_q, v3_q, v4_q;
  logic [SW-1:0]        a1_q, b1_q, c1_q;
  logic [PW-1:0]        p1_q, p2_q, p3_q, p4_q;
  logic [PW-1:0]        fa_q, fb_q, fc_q;
  logic [MW-1:0]        left_q, right_q;
  logic [MW-1:0]        ll_q, lh_q, hl_q, hh_q;
  logic [2*MW-1:0]      prod_d;

  // Heron factor P - 2s, clamped at zero
  function automatic logic [PW-1:0] heron_factor(logic [PW-1:0] p, logic [SW-1:0] s);
    logic [PW-1:0] s2;
    s2 = {1'b0, s, 1'b0};
    return (s2 > p) ? '0 : p - s2;
  endfunction

  assign busy = 1'b0;

  // Register the vertices
  always_ff @(posedge clk_i) begin
    ax_q <= ax_i;
    ay_q <= ay_i;
    bx_q <= bx_i;
    by_q <= by_coord_i;
    cx_q <= cx_i;
    cy_q <= cy_i;
  end

  // Valid bits through the input register, the side units and the product stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vin_q <= 1'b0;
      for (int i = 0; i < SL; i++) vs_q[i] <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      vin_q   <= start & ~busy;
      vs_q[0] <= vin_q;
      for (int i = 1; i < SL; i++) vs_q[i] <= vs_q[i-1];
      v1_q <= vs_q[SL-1];
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  // Side lengths in Q.8
  tpa_side u_side_a (
    .clk_i  (clk_i),
    .x1_i   (ax_q),
    .y1_i   (ay_q),
    .x2_i   (bx_q),
    .y2_i   (by_q),
    .side_o (side_a)
  );

  tpa_side u_side_b (
    .clk_i  (clk_i),
    .x1_i   (bx_q),
    .y1_i   (by_q),
    .x2_i   (cx_q),
    .y2_i   (cy_q),
    .side_o (side_b)
  );

  tpa_side u_side_c (
    .clk_i  (clk_i),
    .x1_i   (cx_q),
    .y1_i   (cy_q),
    .x2_i   (ax_q),
    .y2_i   (ay_q),
    .side_o (side_c)
  );

  // Perimeter
  always_ff @(posedge clk_i) begin
    a1_q <= side_a;
    b1_q <= side_b;
    c1_q <= side_c;
    p1_q <= PW'(side_a) + PW'(side_b) + PW'(side_c);
  end

  // Heron factors
  always_ff @(posedge clk_i) begin
    p2_q <= p1_q;
    fa_q <= heron_factor(p1_q, a1_q);
    fb_q <= heron_factor(p1_q, b1_q);
    fc_q <= heron_factor(p1_q, c1_q);
  end

  // Pair products
  always_ff @(posedge clk_i) begin
    p3_q    <= p2_q;
    left_q  <= MW'(p2_q) * MW'(fa_q);
    right_q <= MW'(fb_q) * MW'(fc_q);
  end

  // Partial products of the full product
  always_ff @(posedge clk_i) begin
    p4_q <= p3_q;
    ll_q <= left_q[HW-1:0]  * right_q[HW-1:0];
    lh_q <= left_q[HW-1:0]  * right_q[MW-1:HW];
    hl_q <= left_q[MW-1:HW] * right_q[HW-1:0];
    hh_q <= left_q[MW-1:HW] * right_q[MW-1:HW];
  end

  // Combine partial products; the root unit registers the sum
  assign prod_d = {hh_q, {MW{1'b0}}}
                + {{(HW-1){1'b0}}, ({1'b0, lh_q} + {1'b0, hl_q}), {HW{1'b0}}}
                + {{MW{1'b0}}, ll_q};

  tpa_root u_root (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v4_q),
    .perim_i (p4_q),
    .rad_i   (prod_d),
    .valid_o (done_o),
    .perim_o (perimeter_q8_o),
    .area_o  (area_q8_o)
  );

  // Every taken item leaves after the fixed latency
  a_latency_fwd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##(tpa_pkg::TOTAL_LAT) done_o)
    else $error("item did not complete after pipeline latency");

  // No result without a matching taken item
  a_latency_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, tpa_pkg::TOTAL_LAT))
    else $error("result strobe without matching item");

  // Zero perimeter gives zero area
  a_zero_area: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && perimeter_q8_o == '0) |-> (area_q8_o == '0))
    else $error("nonzero area with zero perimeter");

endmodule

`default_nettype wire

// ===== rtl/tpa_side.sv =====
`default_nettype none

module tpa_side (
  input  wire logic                                clk_i,
  input  wire logic signed [tpa_pkg::COORD_W-1:0]  x1_i,
  input  wire logic signed [tpa_pkg::COORD_W-1:0]  y1_i,
  input  wire logic signed [tpa_pkg::COORD_W-1:0]  x2_i,
  input  wire logic signed [tpa_pkg::COORD_W-1:0]  y2_i,
  output logic             [tpa_pkg::SIDE_K-1:0]   side_o
);

  localparam int unsigned K  = tpa_pkg::SIDE_K;
  localparam int unsigned RW = tpa_pkg::SIDE_RW;
  localparam int unsigned CW = tpa_pkg::COORD_W;

  logic signed [CW:0]   diff_x, diff_y;
  logic [CW-1:0]        dx_q, dy_q;
  logic [2*CW-1:0]      sqx_q, sqy_q;
  logic [2*CW:0]        sq_sum;

  logic [RW-1:0]        rad_q  [K];
  logic [K+1:0]         rem_q  [K];
  logic [K-1:0]         root_q [K+1];

  // Absolute coordinate differences
  assign diff_x = {x1_i[CW-1], x1_i} - {x2_i[CW-1], x2_i};
  assign diff_y = {y1_i[CW-1], y1_i} - {y2_i[CW-1], y2_i};

  always_ff @(posedge clk_i) begin
    dx_q <= diff_x[CW] ? CW'(-diff_x) : diff_x[CW-1:0];
    dy_q <= diff_y[CW] ? CW'(-diff_y) : diff_y[CW-1:0];
  end

  // Square each difference
  always_ff @(posedge clk_i) begin
    sqx_q <= dx_q * dx_q;
    sqy_q <= dy_q * dy_q;
  end

  // Sum and scale into Q.16 before the root
  assign sq_sum = {1'b0, sqx_q} + {1'b0, sqy_q};

  always_ff @(posedge clk_i) begin
    rad_q[0]  <= {1'b0, sq_sum, 16'b0};
    rem_q[0]  <= '0;
    root_q[0] <= '0;
  end

  // Restoring square root, one root bit per stage
  for (genvar k = 0; k < K; k++) begin : g_step
    logic [K+1:0] cur, trial;
    logic         ge;

    assign cur   = {rem_q[k][K-1:0], rad_q[k][RW-1 -: 2]};
    assign trial = {root_q[k], 2'b01};
    assign ge    = cur >= trial;

    always_ff @(posedge clk_i) begin
      root_q[k+1] <= {root_q[k][K-2:0], ge};
    end

    if (k < K - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        rad_q[k+1] <= rad_q[k] << 2;
        rem_q[k+1] <= ge ? cur - trial : cur;
      end
    end
  end

  assign side_o = root_q[K];

endmodule

`default_nettype wire

// ===== rtl/tpa_root.sv =====
`default_nettype none

module tpa_root (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            valid_i,
  input  wire logic [tpa_pkg::PERIM_W-1:0]     perim_i,
  input  wire logic [tpa_pkg::AREA_RW-1:0]     rad_i,
  output logic                                 valid_o,
  output logic      [tpa_pkg::PERIM_W-1:0]     perim_o,
  output logic      [tpa_pkg::AREA_W-1:0]      area_o
);

  localparam int unsigned K  = tpa_pkg::AREA_K;
  localparam int unsigned RW = tpa_pkg::AREA_RW;
  localparam int unsigned SH = tpa_pkg::AREA_SHIFT;
  localparam int unsigned AW = tpa_pkg::AREA_W;

  logic                          v_q    [K+1];
  logic [tpa_pkg::PERIM_W-1:0]   perim_q[K+1];
  logic [RW-1:0]                 rad_q  [K];
  logic [K+1:0]                  rem_q  [K];
  logic [K-1:0]                  root_q [K+1];

  // Advance valid bits alongside the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= K; i++) v_q[i] <= 1'b0;
    end else begin
      v_q[0] <= valid_i;
      for (int i = 1; i <= K; i++) v_q[i] <= v_q[i-1];
    end
  end

  // Load the product and the perimeter that rides along
  always_ff @(posedge clk_i) begin
    rad_q[0]   <= rad_i;
    rem_q[0]   <= '0;
    root_q[0]  <= '0;
    perim_q[0] <= perim_i;
  end

  // Restoring square root, one root bit per stage
  for (genvar k = 0; k < K; k++) begin : g_step
    logic [K+1:0] cur, trial;
    logic         ge;

    assign cur   = {rem_q[k][K-1:0], rad_q[k][RW-1 -: 2]};
    assign trial = {root_q[k], 2'b01};
    assign ge    = cur >= trial;

    always_ff @(posedge clk_i) begin
      root_q[k+1]  <= {root_q[k][K-2:0], ge};
      perim_q[k+1] <= perim_q[k];
    end

    if (k < K - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        rad_q[k+1] <= rad_q[k] << 2;
        rem_q[k+1] <= ge ? cur - trial : cur;
      end
    end
  end

  // Drop the ten extra fraction bits of the root
  assign valid_o = v_q[K];
  assign perim_o = perim_q[K];
  assign area_o  = root_q[K][SH +: AW];

endmodule

`default_nettype wire

// ===== test/triangle_perimeter_area_tb.sv =====
`default_nettype none

module triangle_perimeter_area_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [tpa_pkg::COORD_W-1:0] coord_t;

  typedef struct packed {
    logic [tpa_pkg::PERIM_W-1:0] perimeter;
    logic [tpa_pkg::AREA_W-1:0]  area;
  } shape_t;

  localparam int unsigned CYCLE_LIMIT = 400000;

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  coord_t ax_i, ay_i, bx_i, by_coord_i, cx_i, cy_i;
  logic done_o;
  logic [tpa_pkg::PERIM_W-1:0] perimeter_q8_o;
  logic [tpa_pkg::AREA_W-1:0]  area_q8_o;

  shape_t shapes_due[$];
  int unsigned errors;
  int unsigned items_sent;
  int unsigned results_seen;
  int unsigned degenerate_seen;
  longint unsigned cycles;

  triangle_perimeter_area u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .ax_i           (ax_i),
    .ay_i           (ay_i),
    .bx_i           (bx_i),
    .by_coord_i     (by_coord_i),
    .cx_i           (cx_i),
    .cy_i           (cy_i),
    .done_o         (done_o),
    .perimeter_q8_o (perimeter_q8_o),
    .area_q8_o      (area_q8_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Integer square root, rounded down, of a value up to 128 bits
  function automatic logic [63:0] floor_root(input logic [127:0] n, input int bits);
    logic [63:0]  r;
    logic [63:0]  t;
    logic [127:0] sq;
    r = '0;
    for (int i = bits - 1; i >= 0; i--) begin
      t  = r | (64'd1 << i);
      sq = 128'(t) * 128'(t);
      if (sq <= n) r = t;
    end
    return r;
  endfunction

  // Side length in Q.8 between two vertices
  function automatic logic [63:0] edge_len(input coord_t x1, y1, x2, y2);
    logic [63:0] dx;
    logic [63:0] dy;
    dx = (x1 >= x2) ? 64'(longint'(x1) - longint'(x2)) : 64'(longint'(x2) - longint'(x1));
    dy = (y1 >= y2) ? 64'(longint'(y1) - longint'(y2)) : 64'(longint'(y2) - longint'(y1));
    return floor_root(128'((dx * dx + dy * dy) << 16), 32);
  endfunction

  // Heron factor P - 2s, clamped at zero
  function automatic logic [63:0] heron_term(input logic [63:0] p, s);
    return (2 * s > p) ? 64'd0 : p - 2 * s;
  endfunction

  function automatic shape_t measure(input coord_t ax, ay, bx, by, cx, cy);
    logic [63:0] a, b, c, p, left, right, root;
    shape_t res;
    a     = edge_len(ax, ay, bx, by);
    b     = edge_len(bx, by, cx, cy);
    c     = edge_len(cx, cy, ax, ay);
    p     = a + b + c;
    left  = p * heron_term(p, a);
    right = heron_term(p, b) * heron_term(p, c);
    root  = floor_root(128'(left) * 128'(right), 64);
    res.perimeter = p[tpa_pkg::PERIM_W-1:0];
    res.area      = tpa_pkg::AREA_W'(root >> tpa_pkg::AREA_SHIFT);
    return res;
  endfunction

  // Send one item, predict its result, then sometimes idle for a random gap between bursts
  task automatic send_triangle(input coord_t ax, ay, bx, by, cx, cy);
    shape_t exp_res;
    ax_i = ax; ay_i = ay; bx_i = bx; by_coord_i = by; cx_i = cx; cy_i = cy;
    start = 1'b1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    exp_res = measure(ax, ay, bx, by, cx, cy);
    shapes_due.push_back(exp_res);
    if (exp_res.area == '0) degenerate_seen++;
    items_sent++;
    @(negedge clk_i);
    // Hold start through a burst, drop it between bursts
    if ($urandom_range(0, 5) == 0) begin
      start = 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
    end
  endtask

  function automatic coord_t rand_coord(input int span);
    if (span >= 32768) return coord_t'($urandom());
    return coord_t'($urandom_range(0, 2 * span) - span);
  endfunction

  // Extremes, axis-aligned, collinear, coincident and sign flips
  task automatic test_directed();
    send_triangle(0, 0, 0, 0, 0, 0);
    send_triangle(0, 0, 1, 0, 0, 1);
    send_triangle(-32768, -32768, 32767, -32768, -32768, 32767);
    send_triangle(-32768, -32768, 32767, 32767, 32767, -32768);
    send_triangle(32767, 32767, -32768, -32768, -32768, 32767);
    send_triangle(-32768, 0, 32767, 0, 0, 32767);
    send_triangle(0, -32768, 0, 32767, -32768, 0);
    send_triangle(-32768, -32768, 32767, 32767, -32768, -32768);
    send_triangle(0, 0, 10, 10, 20, 20);
    send_triangle(-32768, -32768, 0, 0, 32767, 32767);
    send_triangle(5, 5, 5, 5, 9, -3);
    send_triangle(1, 1, 1, 1, 1, 1);
    send_triangle(0, 0, 3, 0, 0, 4);
    send_triangle(-1, -1, -1, 1, 1, -1);
    send_triangle(32767, 0, -32768, 1, 0, -32768);
    send_triangle(0, 0, 65535 / 3, 1, -21845, -1);
    send_triangle(-21846, 100, 21845, 101, 0, 99);
    send_triangle(16'h5555, 16'haaaa, 16'haaaa, 16'h5555, 16'h7fff, 16'h8000);
    send_triangle(16'haaaa, 16'h5555, 16'h5555, 16'haaaa, 16'h8000, 16'h7fff);
  endtask

  // Random triangles: mostly full range, some small, some nearly flat
  task automatic test_random(input int count);
    coord_t ax, ay, bx, by, cx, cy;
    int span;
    int dx, dy;
    for (int n = 0; n < count; n++) begin
      case ($urandom_range(0, 3))
        0: span = 32768;
        1: span = 1 << $urandom_range(0, 14);
        2: span = 32768;
        default: span = 1 << $urandom_range(4, 15);
      endcase
      ax = rand_coord(span); ay = rand_coord(span);
      bx = rand_coord(span); by = rand_coord(span);
      if ($urandom_range(0, 4) == 0) begin
        // Third vertex on or near the line through the first two
        dx = int'(bx) - int'(ax);
        dy = int'(by) - int'(ay);
        cx = coord_t'(int'(ax) + dx / 2 + int'($urandom_range(0, 2)) - 1);
        cy = coord_t'(int'(ay) + dy / 2 + int'($urandom_range(0, 2)) - 1);
      end else begin
        cx = rand_coord(span); cy = rand_coord(span);
      end
      send_triangle(ax, ay, bx, by, cx, cy);
    end
  endtask

  // Compare each strobed result with the oldest prediction
  always @(posedge clk_i) begin
    shape_t exp_res;
    if (rst_ni && done_o) begin
      results_seen++;
      if (shapes_due.size() == 0) begin
        $error("result with no item outstanding: perimeter_q8 %0d area_q8 %0d",
               perimeter_q8_o, area_q8_o);
        errors++;
      end else begin
        exp_res = shapes_due.pop_front();
        if (perimeter_q8_o !== exp_res.perimeter) begin
          $error("perimeter_q8 mismatch: expected %0d actual %0d",
                 exp_res.perimeter, perimeter_q8_o);
          errors++;
        end
        if (area_q8_o !== exp_res.area) begin
          $error("area_q8 mismatch: expected %0d actual %0d", exp_res.area, area_q8_o);
          errors++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    errors = 0; items_sent = 0; results_seen = 0; degenerate_seen = 0; cycles = 0;
    start = 1'b0;
    ax_i = '0; ay_i = '0; bx_i = '0; by_coord_i = '0; cx_i = '0; cy_i = '0;
    rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_directed();
    test_random(850);

    start = 1'b0;
    while (shapes_due.size() != 0) @(posedge clk_i);
    repeat (tpa_pkg::TOTAL_LAT + 8) @(posedge clk_i);

    $display("%0d triangles sent, %0d results checked, %0d with zero area",
             items_sent, results_seen, degenerate_seen);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", errors);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
rtl/tpa_pkg.sv
rtl/tpa_side.sv
rtl/tpa_root.sv
rtl/triangle_perimeter_area.sv
test/triangle_perimeter_area_tb.sv
